@@ src/mbrpc_pkg.sv @@
// Shared types and codes for the bounding-box predicate compare block.
// Self-contained; imported by the design modules of the block.
`timescale 1ns / 1ps
`default_nettype none

package mbrpc_pkg;

    // Spatial predicate codes; codes 5 to 7 are unused and always fail.
    typedef enum logic [2:0] {
        PRED_INTERSECT = 3'd0,
        PRED_CONTAIN   = 3'd1,
        PRED_WITHIN    = 3'd2,
        PRED_EQUAL     = 3'd3,
        PRED_DISJOINT  = 3'd4
    } t_pred;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PREDICATE    = 2'd0;
    localparam logic [1:0] CFG_COORD_SIGNED = 2'd1;
    localparam logic [1:0] CFG_CHECK_DATA   = 2'd2;
    localparam logic [1:0] CFG_REF_BYTES    = 2'd3;

    localparam int CFG_DATA_W = 4;

    // Reset values of the configuration registers.
    localparam logic [2:0] RST_PREDICATE    = 3'd0;
    localparam logic       RST_COORD_SIGNED = 1'b1;
    localparam logic       RST_CHECK_DATA   = 1'b0;
    localparam logic [3:0] RST_REF_BYTES    = 4'd4;

    typedef struct packed {
        logic [2:0] predicate;
        logic       coord_signed;
        logic       check_data;
        logic [3:0] ref_bytes;
    } t_cfg;

endpackage

`default_nettype wire

@@ src/mbrpc_dim_test.sv @@
// Per-dimension predicate test on one set of box bounds.
// Depends on mbrpc_pkg for the configuration struct and predicate codes.
`timescale 1ns / 1ps
`default_nettype none

module mbrpc_dim_test #(
    parameter int COORD_WIDTH = 64
) (
    input  mbrpc_pkg::t_cfg          i_cfg,
    input  wire [COORD_WIDTH-1:0]    i_a_min,
    input  wire [COORD_WIDTH-1:0]    i_a_max,
    input  wire [COORD_WIDTH-1:0]    i_b_min,
    input  wire [COORD_WIDTH-1:0]    i_b_max,
    output logic                     o_fail
);
    import mbrpc_pkg::*;

    localparam logic [COORD_WIDTH-1:0] SIGN_BIT = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [COORD_WIDTH-1:0] flip;
    logic [COORD_WIDTH-1:0] a_lo, a_hi, b_lo, b_hi;

    // Flip the sign bit so unsigned order gives two's complement order.
    assign flip = i_cfg.coord_signed ? SIGN_BIT : '0;
    assign a_lo = i_a_min ^ flip;
    assign a_hi = i_a_max ^ flip;
    assign b_lo = i_b_min ^ flip;
    assign b_hi = i_b_max ^ flip;

    always_comb begin
        unique case (i_cfg.predicate)
            PRED_INTERSECT: o_fail = (a_lo > b_hi) || (b_lo > a_hi);
            PRED_CONTAIN:   o_fail = (b_lo > a_lo) || (b_hi < a_hi);
            PRED_WITHIN:    o_fail = (a_lo > b_lo) || (a_hi < b_hi);
            PRED_EQUAL:     o_fail = (a_lo != b_lo) || (a_hi != b_hi);
            PRED_DISJOINT:  o_fail = (a_lo <= b_hi) && (b_lo <= a_hi);
            default:        o_fail = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

@@ src/mbrpc_ref_cmp.sv @@
// Byte-wise record reference compare, most significant used byte first.
// Depends on mbrpc_pkg for the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module mbrpc_ref_cmp #(
    parameter int MAX_REF_BYTES = 8
) (
    input  mbrpc_pkg::t_cfg            i_cfg,
    input  wire [8*MAX_REF_BYTES-1:0]  i_a_ref,
    input  wire [8*MAX_REF_BYTES-1:0]  i_b_ref,
    output logic signed [8:0]          o_diff
);
    import mbrpc_pkg::*;

    localparam logic [3:0] MAX_N = 4'(MAX_REF_BYTES);

    logic [3:0] n_eff;

    // Clamp the configured length into 1..MAX_REF_BYTES.
    always_comb begin
        priority if (i_cfg.ref_bytes == 4'd0) begin
            n_eff = 4'd1;
        end else if (i_cfg.ref_bytes > MAX_N) begin
            n_eff = MAX_N;
        end else begin
            n_eff = i_cfg.ref_bytes;
        end
    end

    // Scan up from byte 0; a higher differing byte overrides, so the
    // first differing byte in big-endian order wins.
    always_comb begin
        o_diff = '0;
        for (int k = 0; k < MAX_REF_BYTES; k++) begin
            if ((4'(k) < n_eff) && (i_a_ref[8*k +: 8] != i_b_ref[8*k +: 8])) begin
                o_diff = $signed({1'b0, i_a_ref[8*k +: 8]})
                       - $signed({1'b0, i_b_ref[8*k +: 8]});
            end
        end
    end

endmodule

`default_nettype wire

@@ src/mbr_predicate_compare_core.sv @@
// Top level of the bounding-box predicate compare block.
// Depends on mbrpc_pkg, mbrpc_dim_test and mbrpc_ref_cmp.
//
// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  ------------------------------------------
// request   in         i_valid / o_stall    a/b min/max, a/b ref, last_dim
// result    out        o_valid / i_stall    match, ref_diff (one per last dimension)
// config    in         i_cfg_we             i_cfg_index, i_cfg_wdata
//
// One request per cycle is accepted while o_stall is low; a last-dimension
// request reaches the result through the input register, the single compare
// stage between the two registers, then the result register.
// A stalled result holds the result register; only last-dimension requests
// need it, so other dimensions keep flowing while a result waits.
// Reset (synchronous, active low) empties both stages, clears the sticky
// fail flag and loads the configuration reset values.
`timescale 1ns / 1ps
`default_nettype none

module mbr_predicate_compare_core #(
    parameter int COORD_WIDTH   = 64,
    parameter int MAX_REF_BYTES = 8
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,

    input  wire                               i_cfg_we,
    input  wire [1:0]                         i_cfg_index,
    input  wire [mbrpc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,

    input  wire                               i_valid,
    output logic                              o_stall,
    input  wire [63:0]                        i_a_min,
    input  wire [63:0]                        i_a_max,
    input  wire [63:0]                        i_b_min,
    input  wire [63:0]                        i_b_max,
    input  wire [63:0]                        i_a_ref,
    input  wire [63:0]                        i_b_ref,
    input  wire                               i_last_dim,

    output logic                              o_valid,
    input  wire                               i_stall,
    output logic                              o_match,
    output logic signed [8:0]                 o_ref_diff
);
    import mbrpc_pkg::*;

    localparam int REF_W = 8 * MAX_REF_BYTES;

    // Configuration registers.
    t_cfg r_cfg;

    // Input stage.
    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic [COORD_WIDTH-1:0] r_a_min, r_a_max, r_b_min, r_b_max;
    logic [REF_W-1:0]       r_a_ref, r_b_ref;

    // Sticky fail flag across the dimensions of one key.
    logic r_fail_seen, n_fail_seen;

    // Result stage.
    logic              r_out_valid;
    logic              r_match, n_match;
    logic signed [8:0] r_diff, n_diff;

    logic              dim_fail;
    logic              fail_all;
    logic signed [8:0] cmp_diff;
    logic              out_free;
    logic              s1_adv;
    logic              s1_free;
    logic              in_take;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.predicate    <= RST_PREDICATE;
            r_cfg.coord_signed <= RST_COORD_SIGNED;
            r_cfg.check_data   <= RST_CHECK_DATA;
            r_cfg.ref_bytes    <= RST_REF_BYTES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PREDICATE:    r_cfg.predicate    <= i_cfg_wdata[2:0];
                CFG_COORD_SIGNED: r_cfg.coord_signed <= i_cfg_wdata[0];
                CFG_CHECK_DATA:   r_cfg.check_data   <= i_cfg_wdata[0];
                CFG_REF_BYTES:    r_cfg.ref_bytes    <= i_cfg_wdata[3:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    // The result register is free when empty or being drained this cycle.
    assign out_free = !r_out_valid || !i_stall;
    // Only a last dimension needs the result register to move on.
    assign s1_adv   = r_s1_valid && (!r_s1_last || out_free);
    assign s1_free  = !r_s1_valid || s1_adv;
    assign o_stall  = !s1_free;
    assign in_take  = i_valid && s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_valid;
        end
    end

    // Capture the request; only the used coordinate and reference bits.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_last <= i_last_dim;
            r_a_min   <= i_a_min[COORD_WIDTH-1:0];
            r_a_max   <= i_a_max[COORD_WIDTH-1:0];
            r_b_min   <= i_b_min[COORD_WIDTH-1:0];
            r_b_max   <= i_b_max[COORD_WIDTH-1:0];
            r_a_ref   <= i_a_ref[REF_W-1:0];
            r_b_ref   <= i_b_ref[REF_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Compare stage
    // ------------------------------------------------------------------
    mbrpc_dim_test #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dim_test (
        .i_cfg   (r_cfg),
        .i_a_min (r_a_min),
        .i_a_max (r_a_max),
        .i_b_min (r_b_min),
        .i_b_max (r_b_max),
        .o_fail  (dim_fail)
    );

    mbrpc_ref_cmp #(
        .MAX_REF_BYTES (MAX_REF_BYTES)
    ) u_ref_cmp (
        .i_cfg   (r_cfg),
        .i_a_ref (r_a_ref),
        .i_b_ref (r_b_ref),
        .o_diff  (cmp_diff)
    );

    assign fail_all = r_fail_seen || dim_fail;

    always_comb begin
        // Report the reference difference only when the boxes matched and
        // data checking is on.
        n_diff      = (!fail_all && r_cfg.check_data) ? cmp_diff : '0;
        n_match     = !fail_all && (n_diff == '0);
        // Clear after the last dimension, gather otherwise.
        n_fail_seen = r_s1_last ? 1'b0 : fail_all;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_seen <= 1'b0;
        end else if (s1_adv) begin
            r_fail_seen <= n_fail_seen;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_adv && r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last) begin
            r_match <= n_match;
            r_diff  <= n_diff;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_match    = r_match;
    assign o_ref_diff = r_diff;

endmodule

`default_nettype wire

@@ src/mbrpc_checker.sv @@
// Port-level checks on the result channel of the predicate compare block.
// Attached to mbr_predicate_compare_core by the bind at the end of this file.
`timescale 1ns / 1ps
`default_nettype none

module mbrpc_checker (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_out_valid,
    input wire              i_out_stall,
    input wire              i_match,
    input wire signed [8:0] i_ref_diff
);

    // Hold a stalled result.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_match)
                                       && $stable(i_ref_diff))
        else $error("stalled result changed");

    // A match never carries a reference difference.
    a_match_no_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_match |-> i_ref_diff == 9'sd0)
        else $error("match with nonzero reference difference");

    // A nonzero difference is always a mismatch and in byte range.
    a_diff_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_ref_diff != 9'sd0) |-> !i_match && (i_ref_diff != -9'sd256))
        else $error("reference difference inconsistent");

    // Drop any result after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind mbr_predicate_compare_core mbrpc_checker u_mbrpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_match     (o_match),
    .i_ref_diff  (o_ref_diff)
);

`default_nettype wire
